// ----- design/pts_pkg.sv -----
package pts_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // signed numerators, unsigned divider operands
  localparam int NUM_W = 3 * WORD_BITS + 8;
  localparam int DIV_W = 6 * WORD_BITS + 8;

  localparam int FRONT_STAGES = 6;
  localparam int DIV_STAGES   = WORD_BITS + 1;
  localparam int PIPE_LAT     = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        uword_t;
  typedef logic signed [NUM_W-1:0]     num_t;
  typedef logic [DIV_W-1:0]            dword_t;

  typedef struct packed {
    logic   kind;
    word_t  start_pos;
    word_t  start_vel;
    word_t  start_acc;
    word_t  end_pos;
    word_t  end_vel;
    word_t  end_acc;
    uword_t end_time;
  } req_t;

  typedef struct packed {
    word_t      coef0;
    word_t      coef1;
    word_t      coef2;
    word_t      coef3;
    word_t      coef4;
    word_t      coef5;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic  kind;
    logic  zero;
    word_t coef0;
    word_t coef1;
    word_t coef2;
  } side_t;

  typedef struct packed {
    dword_t x;
    dword_t d;
    logic   neg;
  } div_req_t;

  typedef struct packed {
    logic  sat;
    word_t value;
  } div_res_t;

  // round(n * 2^sh / den) becomes floor(x / d) with x = |n| << (sh+1) + den, d = 2 den
  function automatic div_req_t mk_div(num_t n, dword_t den, int sh);
    logic [NUM_W-1:0] mag;
    div_req_t         r;
    mag   = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
    r.x   = (DIV_W'(mag) << (sh + 1)) + den;
    r.d   = den << 1;
    r.neg = n[NUM_W-1];
    return r;
  endfunction

endpackage

// ----- design/pts_front.sv -----
module pts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pts_pkg::req_t     req_i,
  output logic              valid_o,
  output pts_pkg::side_t    side_o,
  output pts_pkg::div_req_t div3_o,
  output pts_pkg::div_req_t div4_o,
  output pts_pkg::div_req_t div5_o
);

  localparam int W = pts_pkg::WORD_BITS;
  localparam int F = pts_pkg::FRAC_BITS;
  localparam int N = pts_pkg::NUM_W;
  localparam int D = pts_pkg::DIV_W;

  logic [pts_pkg::FRONT_STAGES-1:0] v_q;

  // stage 1: differences and first products
  logic signed [W:0]   t33;
  logic signed [W:0]   a33;
  logic [W:0]          amag;
  logic [W:0]          ahalf;
  pts_pkg::side_t      s1_side_d, s1_side_q;
  logic signed [W:0]   s1_dp_d, s1_dp_q, s1_dv_d, s1_dv_q, s1_da_d, s1_da_q;
  logic signed [2*W:0] s1_a0t_d, s1_a0t_q, s1_v0t_d, s1_v0t_q;
  logic [2*W-1:0]      s1_t2_d, s1_t2_q;
  pts_pkg::word_t      s1_a0_q;
  pts_pkg::uword_t     s1_t_q;

  assign t33   = {1'b0, req_i.end_time};
  assign a33   = (W + 1)'(req_i.start_acc);
  assign amag  = a33[W] ? (W + 1)'(-a33) : (W + 1)'(a33);
  assign ahalf = (amag + 1'b1) >> 1;

  assign s1_side_d.kind  = req_i.kind;
  assign s1_side_d.zero  = (req_i.end_time == '0);
  assign s1_side_d.coef0 = req_i.start_pos;
  assign s1_side_d.coef1 = req_i.start_vel;
  assign s1_side_d.coef2 = a33[W] ? -ahalf[W-1:0] : ahalf[W-1:0];

  assign s1_dp_d  = (W + 1)'(req_i.end_pos) - (W + 1)'(req_i.start_pos);
  assign s1_dv_d  = (W + 1)'(req_i.end_vel) - (W + 1)'(req_i.start_vel);
  assign s1_da_d  = (W + 1)'(req_i.end_acc) - (W + 1)'(req_i.start_acc);
  assign s1_a0t_d = req_i.start_acc * t33;
  assign s1_v0t_d = req_i.start_vel * t33;
  assign s1_t2_d  = req_i.end_time * req_i.end_time;

  // stage 2: wide products as word-sized partial products
  pts_pkg::side_t        s2_side_q;
  logic [W-1:0]          t2lo, t2hi;
  logic signed [2*W+1:0] s2_dn_d, s2_dn_q;
  pts_pkg::num_t         s2_hp_d, s2_hp_q;
  logic [2*W-1:0]        s2_t3lo_d, s2_t3lo_q, s2_t3hi_d, s2_t3hi_q;
  logic [2*W-1:0]        s2_t4ll_d, s2_t4ll_q, s2_t4lh_d, s2_t4lh_q;
  logic [2*W-1:0]        s2_t4hh_d, s2_t4hh_q;
  logic signed [2*W:0]   s2_at2lo_d, s2_at2lo_q, s2_at2hi_d, s2_at2hi_q;
  logic signed [2*W+1:0] s2_dt2lo_d, s2_dt2lo_q, s2_dt2hi_d, s2_dt2hi_q;
  logic signed [2*W+1:0] s2_dat_d, s2_dat_q;
  logic [2*W-1:0]        s2_t2_q;
  pts_pkg::uword_t       s2_t_q;

  assign t2lo = s1_t2_q[W-1:0];
  assign t2hi = s1_t2_q[2*W-1:W];

  assign s2_dn_d    = ((2 * W + 2)'(s1_dv_q) <<< F) - (2 * W + 2)'(s1_a0t_q);
  assign s2_hp_d    = (N'(s1_dp_q) <<< (2 * F + 1)) - (N'(s1_v0t_q) <<< (F + 1));
  assign s2_t3lo_d  = t2lo * s1_t_q;
  assign s2_t3hi_d  = t2hi * s1_t_q;
  assign s2_t4ll_d  = t2lo * t2lo;
  assign s2_t4lh_d  = t2lo * t2hi;
  assign s2_t4hh_d  = t2hi * t2hi;
  assign s2_at2lo_d = s1_a0_q * $signed({1'b0, t2lo});
  assign s2_at2hi_d = s1_a0_q * $signed({1'b0, t2hi});
  assign s2_dt2lo_d = s1_da_q * $signed({1'b0, t2lo});
  assign s2_dt2hi_d = s1_da_q * $signed({1'b0, t2hi});
  assign s2_dat_d   = s1_da_q * $signed({1'b0, s1_t_q});

  // stage 3: sum the partial products, split dn * t
  pts_pkg::side_t        s3_side_q;
  logic [3*W-1:0]        s3_t3_d, s3_t3_q;
  logic [4*W-1:0]        s3_t4_d, s3_t4_q;
  logic signed [3*W:0]   s3_a0t2_d, s3_a0t2_q;
  logic signed [3*W+1:0] s3_dat2_d, s3_dat2_q;
  logic [2*W-1:0]        s3_dtl_d, s3_dtl_q, s3_dtm_d, s3_dtm_q;
  logic signed [W+2:0]   s3_dth_d, s3_dth_q;
  pts_pkg::num_t         s3_hp_q;
  logic signed [2*W+1:0] s3_dn_q, s3_dat_q;
  logic [2*W-1:0]        s3_t2_q;
  pts_pkg::uword_t       s3_t_q;

  assign s3_t3_d   = (3 * W)'(s2_t3lo_q) + ((3 * W)'(s2_t3hi_q) << W);
  assign s3_t4_d   = (4 * W)'(s2_t4ll_q) + ((4 * W)'(s2_t4lh_q) << (W + 1))
                   + ((4 * W)'(s2_t4hh_q) << (2 * W));
  assign s3_a0t2_d = (3 * W + 1)'(s2_at2lo_q) + ((3 * W + 1)'(s2_at2hi_q) <<< W);
  assign s3_dat2_d = (3 * W + 2)'(s2_dt2lo_q) + ((3 * W + 2)'(s2_dt2hi_q) <<< W);
  assign s3_dtl_d  = s2_dn_q[W-1:0] * s2_t_q;
  assign s3_dtm_d  = s2_dn_q[2*W-1:W] * s2_t_q;
  assign s3_dth_d  = $signed(s2_dn_q[2*W+1:2*W]) * $signed({1'b0, s2_t_q});

  // stage 4: residual, dn * t, pieces of t^5
  pts_pkg::side_t        s4_side_q;
  logic signed [3*W+2:0] s4_dnt_d, s4_dnt_q;
  pts_pkg::num_t         s4_hn_d, s4_hn_q;
  logic [2*W-1:0]        s4_t5p_d [4];
  logic [2*W-1:0]        s4_t5p_q [4];
  logic signed [2*W+1:0] s4_dn_q, s4_dat_q;
  logic signed [3*W+1:0] s4_dat2_q;
  logic [4*W-1:0]        s4_t4_q;
  logic [3*W-1:0]        s4_t3_q;
  logic [2*W-1:0]        s4_t2_q;

  assign s4_dnt_d = $signed((3 * W + 3)'(s3_dtl_q))
                  + ($signed((3 * W + 3)'(s3_dtm_q)) <<< W)
                  + ((3 * W + 3)'(s3_dth_q) <<< (2 * W));
  assign s4_hn_d  = s3_hp_q - N'(s3_a0t2_q);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s4_t5p_d[k] = s3_t4_q[k*W +: W] * s3_t_q;
    end
  end

  // stage 5: numerators
  pts_pkg::side_t  s5_side_q;
  pts_pkg::num_t   e_dnt, e_dat, e_dat2, e_dn;
  pts_pkg::num_t   s5_n3_d, s5_n3_q, s5_n4_d, s5_n4_q, s5_n5_d, s5_n5_q;
  logic [5*W-1:0]  s5_t5_d, s5_t5_q;
  logic [4*W-1:0]  s5_t4_q;
  logic [3*W-1:0]  s5_t3_q;
  logic [2*W-1:0]  s5_t2_q;

  assign e_dnt   = pts_pkg::num_t'(s4_dnt_q);
  assign e_dat   = pts_pkg::num_t'(s4_dat_q);
  assign e_dat2  = pts_pkg::num_t'(s4_dat2_q);
  assign e_dn    = pts_pkg::num_t'(s4_dn_q);
  assign s5_t5_d = (5 * W)'(s4_t5p_q[0]) + ((5 * W)'(s4_t5p_q[1]) << W)
                 + ((5 * W)'(s4_t5p_q[2]) << (2 * W)) + ((5 * W)'(s4_t5p_q[3]) << (3 * W));

  always_comb begin
    if (s4_side_q.kind) begin
      s5_n3_d = e_dn * 3 - e_dat;
      s5_n4_d = e_dat - e_dn * 2;
      s5_n5_d = '0;
    end else begin
      s5_n3_d = s4_hn_q * 10 - e_dnt * 8 + e_dat2;
      s5_n4_d = e_dnt * 14 - s4_hn_q * 15 - e_dat2 * 2;
      s5_n5_d = s4_hn_q * 6 - e_dnt * 6 + e_dat2;
    end
  end

  // stage 6: divider operands
  pts_pkg::side_t    s6_side_q;
  pts_pkg::dword_t   den3, den4, den5;
  pts_pkg::div_req_t s6_div3_d, s6_div3_q, s6_div4_d, s6_div4_q, s6_div5_d, s6_div5_q;

  always_comb begin
    if (s5_side_q.kind) begin
      den3 = (D'(s5_t2_q) << 1) + D'(s5_t2_q);
      den4 = D'(s5_t3_q) << 2;
      den5 = D'(1'b1);
    end else begin
      den3 = D'(s5_t3_q) << 1;
      den4 = D'(s5_t4_q) << 1;
      den5 = D'(s5_t5_q) << 1;
    end
  end

  assign s6_div3_d = pts_pkg::mk_div(s5_n3_q, den3, F);
  assign s6_div4_d = pts_pkg::mk_div(s5_n4_q, den4, 2 * F);
  assign s6_div5_d = pts_pkg::mk_div(s5_n5_q, den5, 3 * F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[pts_pkg::FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q  <= s1_side_d;
    s1_dp_q    <= s1_dp_d;
    s1_dv_q    <= s1_dv_d;
    s1_da_q    <= s1_da_d;
    s1_a0t_q   <= s1_a0t_d;
    s1_v0t_q   <= s1_v0t_d;
    s1_t2_q    <= s1_t2_d;
    s1_a0_q    <= req_i.start_acc;
    s1_t_q     <= req_i.end_time;

    s2_side_q  <= s1_side_q;
    s2_dn_q    <= s2_dn_d;
    s2_hp_q    <= s2_hp_d;
    s2_t3lo_q  <= s2_t3lo_d;
    s2_t3hi_q  <= s2_t3hi_d;
    s2_t4ll_q  <= s2_t4ll_d;
    s2_t4lh_q  <= s2_t4lh_d;
    s2_t4hh_q  <= s2_t4hh_d;
    s2_at2lo_q <= s2_at2lo_d;
    s2_at2hi_q <= s2_at2hi_d;
    s2_dt2lo_q <= s2_dt2lo_d;
    s2_dt2hi_q <= s2_dt2hi_d;
    s2_dat_q   <= s2_dat_d;
    s2_t2_q    <= s1_t2_q;
    s2_t_q     <= s1_t_q;

    s3_side_q  <= s2_side_q;
    s3_t3_q    <= s3_t3_d;
    s3_t4_q    <= s3_t4_d;
    s3_a0t2_q  <= s3_a0t2_d;
    s3_dat2_q  <= s3_dat2_d;
    s3_dtl_q   <= s3_dtl_d;
    s3_dtm_q   <= s3_dtm_d;
    s3_dth_q   <= s3_dth_d;
    s3_hp_q    <= s2_hp_q;
    s3_dn_q    <= s2_dn_q;
    s3_dat_q   <= s2_dat_q;
    s3_t2_q    <= s2_t2_q;
    s3_t_q     <= s2_t_q;

    s4_side_q  <= s3_side_q;
    s4_dnt_q   <= s4_dnt_d;
    s4_hn_q    <= s4_hn_d;
    for (int k = 0; k < 4; k++) begin
      s4_t5p_q[k] <= s4_t5p_d[k];
    end
    s4_dn_q    <= s3_dn_q;
    s4_dat_q   <= s3_dat_q;
    s4_dat2_q  <= s3_dat2_q;
    s4_t4_q    <= s3_t4_q;
    s4_t3_q    <= s3_t3_q;
    s4_t2_q    <= s3_t2_q;

    s5_side_q  <= s4_side_q;
    s5_n3_q    <= s5_n3_d;
    s5_n4_q    <= s5_n4_d;
    s5_n5_q    <= s5_n5_d;
    s5_t5_q    <= s5_t5_d;
    s5_t4_q    <= s4_t4_q;
    s5_t3_q    <= s4_t3_q;
    s5_t2_q    <= s4_t2_q;

    s6_side_q  <= s5_side_q;
    s6_div3_q  <= s6_div3_d;
    s6_div4_q  <= s6_div4_d;
    s6_div5_q  <= s6_div5_d;
  end

  assign valid_o = v_q[pts_pkg::FRONT_STAGES-1];
  assign side_o  = s6_side_q;
  assign div3_o  = s6_div3_q;
  assign div4_o  = s6_div4_q;
  assign div5_o  = s6_div5_q;

endmodule

// ----- design/pts_div.sv -----
module pts_div (
  input  logic              clk_i,
  input  pts_pkg::div_req_t req_i,
  output pts_pkg::div_res_t res_o
);

  localparam int W = pts_pkg::WORD_BITS;
  localparam int S = pts_pkg::DIV_STAGES;

  pts_pkg::dword_t r_q  [S];
  pts_pkg::dword_t r_d  [S];
  pts_pkg::dword_t dd_q [S];
  logic [W-1:0]    q_q  [S];
  logic [W-1:0]    q_d  [S];
  logic [S-1:0]    neg_q, big_q;

  logic [W-1:0] lim, lo;
  logic         sat;

  // first stage only flags a quotient that needs more than a word
  assign r_d[0] = req_i.x;
  assign q_d[0] = '0;

  always_ff @(posedge clk_i) begin
    r_q[0]   <= r_d[0];
    q_q[0]   <= q_d[0];
    dd_q[0]  <= req_i.d;
    neg_q[0] <= req_i.neg;
    big_q[0] <= (req_i.x >= (req_i.d << W));
  end

  for (genvar j = 1; j < S; j++) begin : g_stage
    localparam int B = W - j;
    pts_pkg::dword_t sub;
    logic            take;

    assign sub    = dd_q[j-1] << B;
    assign take   = (r_q[j-1] >= sub);
    assign r_d[j] = take ? r_q[j-1] - sub : r_q[j-1];
    assign q_d[j] = {q_q[j-1][W-2:0], take};

    always_ff @(posedge clk_i) begin
      r_q[j]   <= r_d[j];
      q_q[j]   <= q_d[j];
      dd_q[j]  <= dd_q[j-1];
      neg_q[j] <= neg_q[j-1];
      big_q[j] <= big_q[j-1];
    end
  end

  // clamp to the signed word range
  assign lim = neg_q[S-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
  assign sat = big_q[S-1] || (q_q[S-1] > lim);
  assign lo  = sat ? lim : q_q[S-1];

  assign res_o.sat   = sat;
  assign res_o.value = neg_q[S-1] ? -lo : lo;

endmodule

// ----- design/polynomial_trajectory_solver.sv -----
// Channel | Ports                  | Handshake
// request | start_i, busy_o, in_i  | taken when start_i is high and busy_o low
// result  | done_o, res_o          | one-cycle strobe on done_o, no back-pressure
//
// One request may enter every cycle; busy_o never rises.
// The pipeline holds six stages of products and numerators, a
// 33-stage restoring divider per coefficient (a range check, then one
// quotient bit per stage), and one output register. The divider chain sets the depth.
// Reset clears only the valid bits; words in flight are dropped.
module polynomial_trajectory_solver (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  pts_pkg::req_t  in_i,
  output logic           done_o,
  output pts_pkg::res_t  res_o
);

  localparam int S = pts_pkg::DIV_STAGES;

  logic              f_valid;
  pts_pkg::side_t    f_side;
  pts_pkg::div_req_t f_div3, f_div4, f_div5;
  pts_pkg::div_res_t q3, q4, q5;

  pts_pkg::side_t sb_q [S];
  logic [S-1:0]   sb_v_q;
  pts_pkg::side_t sb;

  pts_pkg::res_t res_d, res_q;
  logic          done_q;
  logic          sat;

  assign busy_o = 1'b0;

  pts_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .req_i   (in_i),
    .valid_o (f_valid),
    .side_o  (f_side),
    .div3_o  (f_div3),
    .div4_o  (f_div4),
    .div5_o  (f_div5)
  );

  pts_div u_div3 (.clk_i(clk_i), .req_i(f_div3), .res_o(q3));
  pts_div u_div4 (.clk_i(clk_i), .req_i(f_div4), .res_o(q4));
  pts_div u_div5 (.clk_i(clk_i), .req_i(f_div5), .res_o(q5));

  // carry the pass-through fields alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= '0;
      done_q <= 1'b0;
    end else begin
      sb_v_q <= {sb_v_q[S-2:0], f_valid};
      done_q <= sb_v_q[S-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= f_side;
    for (int k = 1; k < S; k++) begin
      sb_q[k] <= sb_q[k-1];
    end
    res_q <= res_d;
  end

  assign sb  = sb_q[S-1];
  assign sat = q3.sat || q4.sat || (q5.sat && !sb.kind);

  always_comb begin
    if (sb.zero) begin
      res_d        = '0;
      res_d.status = pts_pkg::ST_SINGULAR;
    end else begin
      res_d.coef0  = sb.coef0;
      res_d.coef1  = sb.coef1;
      res_d.coef2  = sb.coef2;
      res_d.coef3  = q3.value;
      res_d.coef4  = q4.value;
      res_d.coef5  = sb.kind ? '0 : q5.value;
      res_d.status = sat ? pts_pkg::ST_SAT : pts_pkg::ST_OK;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- design/pts_checker.sv -----
module pts_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input pts_pkg::req_t in_i,
  input logic          done_o,
  input pts_pkg::res_t res_o
);

  localparam int L = pts_pkg::PIPE_LAT;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##L done_o)
    else $error("result word missing after fixed latency");

  a_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.end_time == '0 |->
      ##L (res_o.status == pts_pkg::ST_SINGULAR && res_o.coef3 == '0 && res_o.coef0 == '0))
    else $error("zero duration not reported as singular");

  a_quartic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.kind && in_i.end_time != '0 |-> ##L (res_o.coef5 == '0))
    else $error("quartic word with nonzero fifth coefficient");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.end_time != '0 |->
      ##L (res_o.coef0 == $past(in_i.start_pos, L) && res_o.status != pts_pkg::ST_SINGULAR))
    else $error("start position not carried to result");

endmodule

bind polynomial_trajectory_solver pts_checker u_pts_checker (.*);

// ----- tb/sv/polynomial_trajectory_solver_tb.sv -----
module polynomial_trajectory_solver_tb;

  typedef logic signed [255:0] wide_t;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_REQS = 1600;

  typedef struct {
    pts_pkg::req_t req;
    logic          typed;
    pts_pkg::res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  pts_pkg::req_t in_i = '0;
  logic busy_o;
  logic done_o;
  pts_pkg::res_t res_o;

  pts_pkg::res_t coef_q[$];
  int   errors = 0;
  int   idle_cycles = 0;

  polynomial_trajectory_solver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .in_i   (in_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  // round(n * 2^sh / d) ties away from zero, clamped to the signed word
  function automatic pts_pkg::word_t round_div(wide_t n, wide_t d, int sh, inout logic sat);
    wide_t mag, q, lim;
    logic  neg;
    neg = n < 0;
    mag = neg ? -n : n;
    q = ((mag <<< (sh + 1)) + d) / (d <<< 1);
    lim = neg ? (wide_t'(1) <<< 31) : (wide_t'(1) <<< 31) - 1;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? pts_pkg::word_t'(-q) : pts_pkg::word_t'(q);
  endfunction

  function automatic pts_pkg::res_t solve_coefs(pts_pkg::req_t r);
    pts_pkg::res_t o;
    logic  sat;
    wide_t p0, v0, a0, p1, v1, a1, t, t2, t3, t4, t5, dn, da, hn, dnt, dat, dat2;
    o = '0;
    sat = 1'b0;
    if (r.end_time == '0) begin
      o.status = pts_pkg::ST_SINGULAR;
      return o;
    end
    p0 = wide_t'(r.start_pos);
    v0 = wide_t'(r.start_vel);
    a0 = wide_t'(r.start_acc);
    p1 = wide_t'(r.end_pos);
    v1 = wide_t'(r.end_vel);
    a1 = wide_t'(r.end_acc);
    t  = wide_t'(r.end_time);
    t2 = t * t;
    t3 = t2 * t;
    t4 = t3 * t;
    t5 = t4 * t;
    dn = ((v1 - v0) <<< pts_pkg::FRAC_BITS) - a0 * t;
    da = a1 - a0;
    dnt = dn * t;
    dat = da * t;
    dat2 = da * t2;
    o.coef0 = r.start_pos;
    o.coef1 = r.start_vel;
    o.coef2 = round_div(a0, 2, 0, sat);
    if (r.kind == 1'b0) begin
      hn = ((p1 - p0) <<< (2 * pts_pkg::FRAC_BITS + 1))
         - ((v0 * t) <<< (pts_pkg::FRAC_BITS + 1)) - a0 * t2;
      o.coef3 = round_div(10 * hn - 8 * dnt + dat2, 2 * t3, pts_pkg::FRAC_BITS, sat);
      o.coef4 = round_div(-15 * hn + 14 * dnt - 2 * dat2, 2 * t4,
                          2 * pts_pkg::FRAC_BITS, sat);
      o.coef5 = round_div(6 * hn - 6 * dnt + dat2, 2 * t5, 3 * pts_pkg::FRAC_BITS, sat);
    end else begin
      o.coef3 = round_div(3 * dn - dat, 3 * t2, pts_pkg::FRAC_BITS, sat);
      o.coef4 = round_div(-2 * dn + dat, 4 * t3, 2 * pts_pkg::FRAC_BITS, sat);
      o.coef5 = '0;
    end
    o.status = sat ? pts_pkg::ST_SAT : pts_pkg::ST_OK;
    return o;
  endfunction

  function automatic pts_pkg::word_t rand_word(logic full);
    if (full) return pts_pkg::word_t'($urandom);
    return pts_pkg::word_t'($urandom_range(2 * 1048576) - 1048576);
  endfunction

  function automatic pts_pkg::req_t rand_req();
    pts_pkg::req_t r;
    logic  full;
    int    pick;
    full = ($urandom_range(7) == 0);
    r.kind      = 1'($urandom_range(1));
    r.start_pos = rand_word(full);
    r.start_vel = rand_word(full);
    r.start_acc = rand_word(full);
    r.end_pos   = rand_word(full);
    r.end_vel   = rand_word(full);
    r.end_acc   = rand_word(full);
    pick = $urandom_range(39);
    if (pick == 0)      r.end_time = '0;
    else if (pick < 6)  r.end_time = pts_pkg::uword_t'($urandom);
    else if (pick < 9)  r.end_time = pts_pkg::uword_t'($urandom_range(65535, 1));
    else r.end_time = pts_pkg::uword_t'($urandom_range(32'h0008_0000, 32'h0000_4000));
    return r;
  endfunction

  function automatic int rand_gap();
    int pick;
    pick = $urandom_range(19);
    if (pick < 12) return 0;
    if (pick < 19) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // idle for a random gap (possibly none), then hold the word until it is taken
  task automatic send_word(pts_pkg::req_t r, pts_pkg::res_t want);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= r;
    do @(posedge clk_i); while (busy_o);
    coef_q.push_back(want);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (coef_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, got %h", $time, res_o);
      end else begin
        pts_pkg::res_t want;
        want = coef_q.pop_front();
        check_field("coef0", want.coef0, res_o.coef0);
        check_field("coef1", want.coef1, res_o.coef1);
        check_field("coef2", want.coef2, res_o.coef2);
        check_field("coef3", want.coef3, res_o.coef3);
        check_field("coef4", want.coef4, res_o.coef4);
        check_field("coef5", want.coef5, res_o.coef5);
        check_field("status", 32'(want.status), 32'(res_o.status));
      end
    end
  end

  // abort when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    pts_pkg::req_t r;
    int   wait_cycles;

    // zero end time, both kinds, extremes elsewhere
    r = '{kind: 1'b0, start_pos: 32'sh7fffffff, start_vel: 32'sh80000000,
          start_acc: 32'sh7fffffff, end_pos: 32'sh80000000, end_vel: 32'sh7fffffff,
          end_acc: 32'sh80000000, end_time: 32'h0};
    rows.push_back('{r, 1'b1, '{0, 0, 0, 0, 0, 0, pts_pkg::ST_SINGULAR}});
    r.kind = 1'b1;
    rows.push_back('{r, 1'b1, '{0, 0, 0, 0, 0, 0, pts_pkg::ST_SINGULAR}});
    // standing still stays still
    r = '0;
    r.end_time = 32'h0001_0000;
    rows.push_back('{r, 1'b1, '{0, 0, 0, 0, 0, 0, pts_pkg::ST_OK}});
    r.kind = 1'b1;
    rows.push_back('{r, 1'b1, '{0, 0, 0, 0, 0, 0, pts_pkg::ST_OK}});
    // quartic ignores end position
    r.end_pos = 32'sh7fffffff;
    rows.push_back('{r, 1'b1, '{0, 0, 0, 0, 0, 0, pts_pkg::ST_OK}});
    // halving ties of the start acceleration
    r = '0;
    r.end_time = 32'h0002_0000;
    r.start_acc = 32'sh00000001;            rows.push_back('{r, 1'b0, '0});
    r.start_acc = -32'sh00000001;           rows.push_back('{r, 1'b0, '0});
    r.start_acc = 32'sh7fffffff;            rows.push_back('{r, 1'b0, '0});
    r.start_acc = 32'sh80000000;            rows.push_back('{r, 1'b0, '0});
    // extremes that saturate, and the longest and shortest times
    for (int k = 0; k < 2; k++) begin
      r = '{kind: k[0], start_pos: 32'sh80000000, start_vel: 32'sh7fffffff,
            start_acc: 32'sh80000000, end_pos: 32'sh7fffffff, end_vel: 32'sh80000000,
            end_acc: 32'sh7fffffff, end_time: 32'h0000_0001};
      rows.push_back('{r, 1'b0, '0});
      r.end_time = 32'hffff_ffff;
      rows.push_back('{r, 1'b0, '0});
      r.end_time = 32'h0001_0000;
      rows.push_back('{r, 1'b0, '0});
      r = '{kind: k[0], start_pos: 32'sh0001_0000, start_vel: 32'sh0002_0000,
            start_acc: -32'sh0001_0000, end_pos: 32'sh000a_0000, end_vel: 32'sh0003_0000,
            end_acc: 32'sh0000_8000, end_time: 32'h0004_0000};
      rows.push_back('{r, 1'b0, '0});
      r.end_time = 32'hffff_ffff;
      rows.push_back('{r, 1'b0, '0});
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      rw = rows[i];
      send_word(rw.req, rw.typed ? rw.res : solve_coefs(rw.req));
    end
    for (int n = 0; n < RANDOM_REQS; n++) begin
      r = rand_req();
      send_word(r, solve_coefs(r));
    end
    start_i <= 1'b0;

    while (coef_q.size() != 0) @(posedge clk_i);
    wait_cycles = pts_pkg::PIPE_LAT + 10;
    repeat (wait_cycles) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
